// File: hdl/rpa_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_pkg
// Shared opcodes, command kinds, store sizes and item types of the
// relocation patch unit.
// ----------------------------------------------------------------------------
package rpa_pkg;

    // Patch opcodes
    localparam logic [7:0] CMD_ADDR32    = 8'd1;
    localparam logic [7:0] CMD_ADDR16_LO = 8'd4;
    localparam logic [7:0] CMD_ADDR16_HI = 8'd5;
    localparam logic [7:0] CMD_ADDR16_HA = 8'd6;
    localparam logic [7:0] CMD_REL24     = 8'd10;
    localparam logic [7:0] CMD_WRITE32   = 8'd32;
    localparam logic [7:0] CMD_WRITE16   = 8'd33;
    localparam logic [7:0] CMD_WRITE8    = 8'd34;
    localparam logic [7:0] CMD_COND_PTR  = 8'd35;
    localparam logic [7:0] CMD_COND32    = 8'd36;
    localparam logic [7:0] CMD_COND16    = 8'd37;
    localparam logic [7:0] CMD_COND8     = 8'd38;
    localparam logic [7:0] CMD_BRANCH    = 8'd64;
    localparam logic [7:0] CMD_BRANCH_LK = 8'd65;

    localparam logic [23:0] ABS_SELECT = 24'hFFFFFE;
    localparam logic [31:0] KEEP_MASK  = 32'hFC000003;
    localparam logic [31:0] FIELD_MASK = 32'h03FFFFFC;
    localparam logic [31:0] OP_B       = 32'h48000000;
    localparam logic [31:0] OP_BL      = 32'h48000001;

    // Store sizes
    localparam logic [1:0] SZ_BYTE = 2'd0;
    localparam logic [1:0] SZ_HALF = 2'd1;
    localparam logic [1:0] SZ_WORD = 2'd2;

    // Depth of the queue between front and back
    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef enum logic [3:0] {
        K_ADDR32,
        K_LO,
        K_HI,
        K_HA,
        K_REL24,
        K_W32,
        K_W16,
        K_W8,
        K_C_PTR,
        K_C32,
        K_C16,
        K_C8,
        K_B,
        K_BL,
        K_UNK
    } t_kind;

    // Classified command as it travels from front to back
    typedef struct packed {
        t_kind       kind;
        logic [31:0] addr;
        logic [31:0] tgt;
        logic [31:0] opv;
        logic [31:0] cmpv;
        logic [31:0] cur;
    } t_item;

    // Handshake between queue and back
    typedef struct packed {
        logic valid;
        logic take;
    } t_qhs;

    // Finished write request
    typedef struct packed {
        logic [31:0] addr;
        logic [31:0] data;
        logic [1:0]  size;
        logic        en;
        logic        unk;
    } t_result;

endpackage
`default_nettype wire

// File: hdl/rpa_front.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_front
// Holds the text base, resolves the target and symbol addresses and
// classifies the opcode of each accepted command.
// ----------------------------------------------------------------------------
module rpa_front (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_valid,
    input  wire logic [31:0]    i_cfg_text_base,
    input  wire logic [7:0]     i_command,
    input  wire logic [23:0]    i_target_offset,
    input  wire logic [31:0]    i_absolute_address,
    input  wire logic [31:0]    i_operand_value,
    input  wire logic [31:0]    i_compare_value,
    input  wire logic [31:0]    i_current_contents,
    output rpa_pkg::t_item      o_item
);

    logic [31:0]      r_text_base;
    rpa_pkg::t_kind   kind;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_text_base <= '0;
        end else if (i_cfg_valid) begin
            r_text_base <= i_cfg_text_base;
        end
    end

    always_comb begin
        unique case (i_command)
            rpa_pkg::CMD_ADDR32:    kind = rpa_pkg::K_ADDR32;
            rpa_pkg::CMD_ADDR16_LO: kind = rpa_pkg::K_LO;
            rpa_pkg::CMD_ADDR16_HI: kind = rpa_pkg::K_HI;
            rpa_pkg::CMD_ADDR16_HA: kind = rpa_pkg::K_HA;
            rpa_pkg::CMD_REL24:     kind = rpa_pkg::K_REL24;
            rpa_pkg::CMD_WRITE32:   kind = rpa_pkg::K_W32;
            rpa_pkg::CMD_WRITE16:   kind = rpa_pkg::K_W16;
            rpa_pkg::CMD_WRITE8:    kind = rpa_pkg::K_W8;
            rpa_pkg::CMD_COND_PTR:  kind = rpa_pkg::K_C_PTR;
            rpa_pkg::CMD_COND32:    kind = rpa_pkg::K_C32;
            rpa_pkg::CMD_COND16:    kind = rpa_pkg::K_C16;
            rpa_pkg::CMD_COND8:     kind = rpa_pkg::K_C8;
            rpa_pkg::CMD_BRANCH:    kind = rpa_pkg::K_B;
            rpa_pkg::CMD_BRANCH_LK: kind = rpa_pkg::K_BL;
            default:                kind = rpa_pkg::K_UNK;
        endcase
    end

    always_comb begin
        o_item.kind = kind;
        o_item.addr = (i_target_offset == rpa_pkg::ABS_SELECT)
                      ? i_absolute_address
                      : r_text_base + {8'd0, i_target_offset};
        // bit 31 marks an absolute symbol
        o_item.tgt  = i_operand_value[31] ? i_operand_value
                                          : r_text_base + i_operand_value;
        o_item.opv  = i_operand_value;
        o_item.cmpv = i_compare_value;
        o_item.cur  = i_current_contents;
    end

endmodule
`default_nettype wire

// File: hdl/rpa_queue.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_queue
// Short first-in first-out queue of classified commands between the
// front and the back.
// ----------------------------------------------------------------------------
module rpa_queue (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_wr,
    input  wire rpa_pkg::t_item i_item,
    output logic                o_full,
    input  wire rpa_pkg::t_qhs  i_hs,
    output logic                o_valid,
    output rpa_pkg::t_item      o_item
);

    rpa_pkg::t_item                 r_mem [rpa_pkg::QDEPTH];
    logic [rpa_pkg::QPTR_W-1:0]     r_wptr;
    logic [rpa_pkg::QPTR_W-1:0]     r_rptr;
    logic [rpa_pkg::QCNT_W-1:0]     r_count;
    logic                           rd;

    assign o_full  = (r_count == rpa_pkg::QCNT_W'(rpa_pkg::QDEPTH));
    assign o_valid = (r_count != '0);
    assign o_item  = r_mem[r_rptr];
    assign rd      = i_hs.valid && i_hs.take;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            if (i_wr) begin
                r_wptr <= (r_wptr == rpa_pkg::QPTR_W'(rpa_pkg::QDEPTH - 1))
                          ? '0 : r_wptr + 1'b1;
            end
            if (rd) begin
                r_rptr <= (r_rptr == rpa_pkg::QPTR_W'(rpa_pkg::QDEPTH - 1))
                          ? '0 : r_rptr + 1'b1;
            end
            if (i_wr && !rd) begin
                r_count <= r_count + 1'b1;
            end else if (!i_wr && rd) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule
`default_nettype wire

// File: hdl/rpa_back.sv
`default_nettype none
// ----------------------------------------------------------------------------
// rpa_back
// Builds the write request for a classified command and holds it in the
// output register until it is taken.
// ----------------------------------------------------------------------------
module rpa_back (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_valid,
    input  wire rpa_pkg::t_item i_item,
    output rpa_pkg::t_qhs       o_hs,
    input  wire logic           i_pop,
    output logic                o_valid,
    output rpa_pkg::t_result    o_res
);

    rpa_pkg::t_result   r_res;
    rpa_pkg::t_result   n_res;
    logic               r_valid;
    logic               take;
    logic [31:0]        delta;
    logic [31:0]        field;
    logic [15:0]        ha;
    logic               eq32;
    logic               eq16;
    logic               eq8;

    assign take     = !r_valid || i_pop;
    assign o_hs     = '{valid: i_valid, take: take};
    assign o_valid  = r_valid;
    assign o_res    = r_res;

    assign delta = i_item.tgt - i_item.addr;
    assign field = delta & rpa_pkg::FIELD_MASK;
    assign ha    = i_item.tgt[31:16] + {15'd0, i_item.tgt[15]};
    assign eq32  = (i_item.cur == i_item.cmpv);
    assign eq16  = (i_item.cur[15:0] == i_item.cmpv[15:0]);
    assign eq8   = (i_item.cur[7:0] == i_item.cmpv[7:0]);

    always_comb begin
        n_res.addr = i_item.addr;
        n_res.data = '0;
        n_res.size = rpa_pkg::SZ_BYTE;
        n_res.en   = 1'b1;
        n_res.unk  = 1'b0;
        unique case (i_item.kind)
            rpa_pkg::K_ADDR32: begin
                n_res.data = i_item.tgt;
                n_res.size = rpa_pkg::SZ_WORD;
            end
            rpa_pkg::K_LO: begin
                n_res.data = {16'd0, i_item.tgt[15:0]};
                n_res.size = rpa_pkg::SZ_HALF;
            end
            rpa_pkg::K_HI: begin
                n_res.data = {16'd0, i_item.tgt[31:16]};
                n_res.size = rpa_pkg::SZ_HALF;
            end
            rpa_pkg::K_HA: begin
                n_res.data = {16'd0, ha};
                n_res.size = rpa_pkg::SZ_HALF;
            end
            rpa_pkg::K_REL24: begin
                n_res.data = (i_item.cur & rpa_pkg::KEEP_MASK) | field;
                n_res.size = rpa_pkg::SZ_WORD;
            end
            rpa_pkg::K_W32: begin
                n_res.data = i_item.opv;
                n_res.size = rpa_pkg::SZ_WORD;
            end
            rpa_pkg::K_W16: begin
                n_res.data = {16'd0, i_item.opv[15:0]};
                n_res.size = rpa_pkg::SZ_HALF;
            end
            rpa_pkg::K_W8: begin
                n_res.data = {24'd0, i_item.opv[7:0]};
                n_res.size = rpa_pkg::SZ_BYTE;
            end
            rpa_pkg::K_C_PTR: begin
                n_res.size = rpa_pkg::SZ_WORD;
                n_res.en   = eq32;
                n_res.data = eq32 ? i_item.tgt : '0;
            end
            rpa_pkg::K_C32: begin
                n_res.size = rpa_pkg::SZ_WORD;
                n_res.en   = eq32;
                n_res.data = eq32 ? i_item.opv : '0;
            end
            rpa_pkg::K_C16: begin
                n_res.size = rpa_pkg::SZ_HALF;
                n_res.en   = eq16;
                n_res.data = eq16 ? {16'd0, i_item.opv[15:0]} : '0;
            end
            rpa_pkg::K_C8: begin
                n_res.size = rpa_pkg::SZ_BYTE;
                n_res.en   = eq8;
                n_res.data = eq8 ? {24'd0, i_item.opv[7:0]} : '0;
            end
            rpa_pkg::K_B: begin
                n_res.data = (rpa_pkg::OP_B & rpa_pkg::KEEP_MASK) | field;
                n_res.size = rpa_pkg::SZ_WORD;
            end
            rpa_pkg::K_BL: begin
                n_res.data = (rpa_pkg::OP_BL & rpa_pkg::KEEP_MASK) | field;
                n_res.size = rpa_pkg::SZ_WORD;
            end
            default: begin
                n_res.en  = 1'b0;
                n_res.unk = 1'b1;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && take) begin
            r_res <= n_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (take) begin
            r_valid <= i_valid;
        end
    end

endmodule
`default_nettype wire

// File: hdl/relocation_patch_apply.sv
`default_nettype none
// ----------------------------------------------------------------------------
// relocation_patch_apply
// Applies one decoded relocation patch command and gives one write request.
// ----------------------------------------------------------------------------
// Usage:
//   Commands enter through a queue-like port: drive the fields and raise push;
//   a command is taken at an edge where push is high and full is low.
//   Write requests leave the same way: while empty is low the oldest request
//   sits on the o_write_* ports, and it is taken at an edge with pop high.
//   The text base is written over its own channel (i_cfg_valid, o_cfg_ready,
//   always ready); write it only while no command is in flight.
//   A taken command passes the queue, then the output register where its
//   request shows. Throughput: one command per cycle unless pop is held low,
//   bounded by the single classify step in front and build step in back.
//   A four-entry queue between front and back absorbs a stalled receiver;
//   full rises once the queue fills while the output register is held.
//   Reset empties the queue and the output register and clears the text
//   base to zero.
// ----------------------------------------------------------------------------
module relocation_patch_apply (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    // configuration
    input  wire logic           i_cfg_valid,
    output logic                o_cfg_ready,
    input  wire logic [31:0]    i_cfg_text_base,
    // command channel
    input  wire logic           push,
    output logic                full,
    input  wire logic [7:0]     i_command,
    input  wire logic [23:0]    i_target_offset,
    input  wire logic [31:0]    i_absolute_address,
    input  wire logic [31:0]    i_operand_value,
    input  wire logic [31:0]    i_compare_value,
    input  wire logic [31:0]    i_current_contents,
    // write request channel
    output logic                empty,
    input  wire logic           pop,
    output logic [31:0]         o_write_address,
    output logic [31:0]         o_write_data,
    output logic [1:0]          o_write_size,
    output logic                o_write_enable,
    output logic                o_unknown_command
);

    rpa_pkg::t_item     front_item;
    rpa_pkg::t_item     q_item;
    rpa_pkg::t_qhs      q_hs;
    rpa_pkg::t_result   res;
    logic               q_full;
    logic               q_valid;
    logic               out_valid;
    logic               accept;

    // Config is always taken at once
    assign o_cfg_ready = 1'b1;

    assign full   = q_full;
    assign accept = push && !q_full;

    // Resolve addresses and classify the opcode
    rpa_front u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cfg_valid        (i_cfg_valid),
        .i_cfg_text_base    (i_cfg_text_base),
        .i_command          (i_command),
        .i_target_offset    (i_target_offset),
        .i_absolute_address (i_absolute_address),
        .i_operand_value    (i_operand_value),
        .i_compare_value    (i_compare_value),
        .i_current_contents (i_current_contents),
        .o_item             (front_item)
    );

    // Hold classified commands until the back is free
    rpa_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_wr    (accept),
        .i_item  (front_item),
        .o_full  (q_full),
        .i_hs    (q_hs),
        .o_valid (q_valid),
        .o_item  (q_item)
    );

    // Build the write request and hold it for the receiver
    rpa_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (q_valid),
        .i_item  (q_item),
        .o_hs    (q_hs),
        .i_pop   (pop),
        .o_valid (out_valid),
        .o_res   (res)
    );

    assign empty             = !out_valid;
    assign o_write_address   = res.addr;
    assign o_write_data      = res.data;
    assign o_write_size      = res.size;
    assign o_write_enable    = res.en;
    assign o_unknown_command = res.unk;

endmodule
`default_nettype wire
